// File: rtl/wll_pkg.sv
// Package for the wear-leveled count log: sizes, payload structs, codes and states.
// Depends on nothing; wear_leveled_count_log and wll_ctrl import it.
`default_nettype none

package wll_pkg;

  localparam int SLOTS  = 100;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int SLOT_W = $clog2(SLOTS + 1);
  localparam int CNT_W  = 16;
  localparam int NEXT_W = 7;

  localparam logic signed [CNT_W-1:0] EMPTY_MARK = 16'sd999;

  typedef enum logic [1:0] {
    KIND_STORE   = 2'd0,
    KIND_RECOVER = 2'd1,
    KIND_ERASE   = 2'd2,
    KIND_NOP     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    kind_t                   kind;
    logic signed [CNT_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] count;
    logic [NEXT_W-1:0]       next_slot;
    logic                    wrapped;
  } rsp_t;

  typedef struct packed {
    logic              busy;
    logic [SLOT_W-1:0] write_slot;
  } stat_t;

  function automatic logic [NEXT_W-1:0] slot_to_next(input logic [SLOT_W-1:0] slot);
    logic [31:0] wide;
    wide = 32'(slot);
    return wide[NEXT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/wear_leveled_count_log.sv
// Top level of the wear-leveled count log: ring RAM, sequencer and result register.
// Depends on wll_pkg, wll_ram and wll_ctrl.
`default_nettype none

// Append-only log of signed 16-bit counts kept in a ring of SLOTS RAM slots.
// kind store writes the value at the next slot (erasing the ring first when it
// is full, flagged by wrapped), recover scans from slot 0 for the first empty
// slot (an entry at or above 999, or one never written since erase) and returns
// the entry before it, erase empties the ring; each command gives one result.
// Store, erase and the unused kind go straight to the done state; recover
// scans, reading one slot per cycle through the single RAM read port.
// Per-slot valid bits are cleared at once by reset and by erase, so no
// clearing pass runs. A result waits in the output register while the next
// command is taken.
module wear_leveled_count_log
  import wll_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output      logic req_ready,
  input  wire req_t req,
  output      logic rsp_valid,
  input  wire logic rsp_ready,
  output      rsp_t rsp
);

  logic              res_valid;
  logic              res_ready;
  rsp_t              res;
  stat_t             stat;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CNT_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CNT_W-1:0]  ram_rdata;

  wll_ram #(
    .WIDTH(CNT_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  wll_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .stat     (stat),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

  a_no_accept_while_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !req_ready)
    else $error("command accepted while a result is pending");

  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (req.kind != KIND_RECOVER)) |=> res_valid)
    else $error("non-scan command gave no result in one cycle");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    stat.write_slot <= SLOT_W'(SLOTS))
    else $error("write slot beyond ring");

  a_wrap_slot: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.wrapped) |-> (res.next_slot == NEXT_W'(1)))
    else $error("wrapped store did not land at slot 0");

  a_ready_when_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !stat.busy)
    else $error("command offered while the sequencer is busy");

endmodule

`default_nettype wire

// File: rtl/wll_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module wll_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 100
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/wll_ctrl.sv
// Sequencer of the count log: slot valid bits, write slot, recover scan over the RAM.
// Depends on wll_pkg; drives one wll_ram instance through its port signals.
`default_nettype none

module wll_ctrl
  import wll_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output      logic              req_ready,
  input  wire req_t              req,
  output      logic              res_valid,
  input  wire logic              res_ready,
  output      rsp_t              res,
  output      stat_t             stat,
  output      logic              ram_we,
  output      logic [ADDR_W-1:0] ram_waddr,
  output      logic [CNT_W-1:0]  ram_wdata,
  output      logic [ADDR_W-1:0] ram_raddr,
  input  wire logic [CNT_W-1:0]  ram_rdata
);

  state_t                  state, state_next;
  logic [SLOTS-1:0]        vld, vld_next;
  logic [SLOT_W-1:0]       ws, ws_next;
  logic signed [CNT_W-1:0] last_count, last_count_next;
  logic [ADDR_W-1:0]       ra, ra_next;
  logic                    ra_live, ra_live_next;
  logic                    pend, pend_next;
  logic [ADDR_W-1:0]       idx_q, idx_q_next;
  logic                    vld_q, vld_q_next;
  logic signed [CNT_W-1:0] prev, prev_next;
  rsp_t                    res_next;
  logic                    empty;
  logic                    wrap;
  logic signed [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      vld        <= '0;
      ws         <= '0;
      last_count <= '0;
      ra_live    <= 1'b0;
      pend       <= 1'b0;
    end else begin
      state      <= state_next;
      vld        <= vld_next;
      ws         <= ws_next;
      last_count <= last_count_next;
      ra_live    <= ra_live_next;
      pend       <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    ra    <= ra_next;
    idx_q <= idx_q_next;
    vld_q <= vld_q_next;
    prev  <= prev_next;
    res   <= res_next;
  end

  always_comb begin
    state_next      = state;
    vld_next        = vld;
    ws_next         = ws;
    last_count_next = last_count;
    ra_next         = ra;
    ra_live_next    = ra_live;
    pend_next       = pend;
    idx_q_next      = idx_q;
    vld_q_next      = vld_q;
    prev_next       = prev;
    res_next        = res;
    req_ready       = 1'b0;
    res_valid       = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = ws[ADDR_W-1:0];
    ram_wdata       = req.value;
    ram_raddr       = ra;
    empty           = !vld_q || ($signed(ram_rdata) >= EMPTY_MARK);
    wrap            = (ws >= SLOT_W'(SLOTS));
    cnt             = '0;

    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          unique case (req.kind)
            KIND_STORE: begin
              ram_we = 1'b1;
              if (wrap) begin
                ram_waddr   = '0;
                vld_next    = '0;
                vld_next[0] = 1'b1;
                ws_next     = SLOT_W'(1);
              end else begin
                vld_next[ws[ADDR_W-1:0]] = 1'b1;
                ws_next                  = ws + SLOT_W'(1);
              end
              res_next.count     = req.value;
              res_next.next_slot = slot_to_next(ws_next);
              res_next.wrapped   = wrap;
              state_next         = ST_DONE;
            end
            KIND_RECOVER: begin
              ra_next      = '0;
              ra_live_next = 1'b1;
              pend_next    = 1'b0;
              state_next   = ST_SCAN;
            end
            KIND_ERASE: begin
              vld_next           = '0;
              ws_next            = '0;
              res_next.count     = '0;
              res_next.next_slot = '0;
              res_next.wrapped   = 1'b0;
              state_next         = ST_DONE;
            end
            default: begin
              res_next.count     = last_count;
              res_next.next_slot = slot_to_next(ws);
              res_next.wrapped   = 1'b0;
              state_next         = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (pend && empty) begin
          cnt                = (idx_q == '0) ? '0 : prev;
          ws_next            = SLOT_W'(idx_q);
          last_count_next    = cnt;
          res_next.count     = cnt;
          res_next.next_slot = slot_to_next(ws_next);
          res_next.wrapped   = 1'b0;
          pend_next          = 1'b0;
          ra_live_next       = 1'b0;
          state_next         = ST_DONE;
        end else if (pend && (idx_q == ADDR_W'(SLOTS - 1))) begin
          cnt                = $signed(ram_rdata);
          ws_next            = SLOT_W'(SLOTS);
          last_count_next    = cnt;
          res_next.count     = cnt;
          res_next.next_slot = slot_to_next(ws_next);
          res_next.wrapped   = 1'b0;
          pend_next          = 1'b0;
          ra_live_next       = 1'b0;
          state_next         = ST_DONE;
        end else begin
          if (pend) begin
            prev_next = $signed(ram_rdata);
          end
          pend_next  = ra_live;
          idx_q_next = ra;
          vld_q_next = vld[ra];
          if (ra == ADDR_W'(SLOTS - 1)) begin
            ra_live_next = 1'b0;
          end else begin
            ra_next = ra + ADDR_W'(1);
          end
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign stat.busy       = (state != ST_IDLE);
  assign stat.write_slot = ws;

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for wear_leveled_count_log: directed, ring-wrap, back-pressure and
// random command tests, checked transfer by transfer against an in-bench log predictor.
// Depends on wll_pkg and the RTL top level only.

module tb_top;
  import wll_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_HOLD   = 300;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  logic signed [CNT_W-1:0] model_ring [SLOTS];
  int                      model_wslot;
  logic signed [CNT_W-1:0] model_last;
  rsp_t                    results_due [$];
  rsp_t                    oldest;

  int          errors       = 0;
  int unsigned cycle_count  = 0;
  logic        steady       = 1'b0;
  int unsigned holds_asked  = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left    = 0;
  int unsigned stall_left   = 0;

  wear_leveled_count_log uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void wipe_model();
    for (int i = 0; i < SLOTS; i++) model_ring[i] = EMPTY_MARK;
    model_wslot = 0;
  endfunction

  function automatic rsp_t log_outcome(input req_t r);
    rsp_t o;
    int   hit;
    o = '0;
    case (r.kind)
      KIND_STORE: begin
        if (model_wslot >= SLOTS) begin
          wipe_model();
          o.wrapped = 1'b1;
        end
        model_ring[model_wslot] = r.value;
        model_wslot++;
        o.count = r.value;
      end
      KIND_RECOVER: begin
        hit = SLOTS;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (model_ring[i] >= EMPTY_MARK) hit = i;
        end
        if (hit == SLOTS) o.count = model_ring[SLOTS-1];
        else if (hit == 0) o.count = '0;
        else o.count = model_ring[hit-1];
        model_wslot = hit;
        model_last  = o.count;
      end
      KIND_ERASE: begin
        wipe_model();
        o.count = '0;
      end
      default: begin
        o.count = model_last;
      end
    endcase
    o.next_slot = model_wslot[NEXT_W-1:0];
    return o;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [CNT_W-1:0] below_mark();
    int t;
    t = $urandom_range(0, 33766);
    return CNT_W'(t - 32768);
  endfunction

  function automatic logic signed [CNT_W-1:0] count_value();
    case ($urandom_range(0, 9))
      0: return CNT_W'($urandom);
      1: return CNT_W'(int'(EMPTY_MARK) + int'($urandom_range(0, 3)) - 1);
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return below_mark();
    endcase
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // predict on every accepted command
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) results_due.push_back(log_outcome(req));
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual count=%0d next_slot=%0d wrapped=%0d",
                 $time, rsp.count, rsp.next_slot, rsp.wrapped);
        errors++;
      end else begin
        oldest = results_due.pop_front();
        check_field("count", int'(oldest.count), int'(rsp.count));
        check_field("next_slot", int'(oldest.next_slot), int'(rsp.next_slot));
        check_field("wrapped", int'(oldest.wrapped), int'(rsp.wrapped));
      end
    end
  end

  // result sink: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
      if (hold_left == 1) holds_served <= holds_served + 1;
    end else if (holds_served != holds_asked) begin
      rsp_ready <= 1'b0;
      hold_left <= LONG_HOLD;
    end else if (stall_left != 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= gap_len();
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("wear_leveled_count_log regression: fail");
      $finish;
    end
  end

  task automatic offer_cmd(input kind_t k, input logic signed [CNT_W-1:0] v);
    int unsigned gap;
    req       <= req_t'{kind: k, value: v};
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    gap = steady ? 0 : gap_len();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    offer_cmd(KIND_RECOVER, 16'sd0);
    offer_cmd(KIND_NOP, 16'sh7fff);
    offer_cmd(KIND_STORE, 16'sh7fff);
    offer_cmd(KIND_STORE, 16'sh8000);
    offer_cmd(KIND_STORE, 16'sd0);
    offer_cmd(KIND_STORE, -16'sd1);
    offer_cmd(KIND_STORE, 16'sd998);
    offer_cmd(KIND_RECOVER, 16'sh5555);
    offer_cmd(KIND_STORE, 16'sd999);
    offer_cmd(KIND_STORE, 16'sd5);
    offer_cmd(KIND_RECOVER, 16'shaaaa);
    offer_cmd(KIND_STORE, 16'sd1000);
    offer_cmd(KIND_RECOVER, 16'sd0);
    offer_cmd(KIND_NOP, 16'sd0);
    offer_cmd(KIND_ERASE, 16'sh8000);
    offer_cmd(KIND_RECOVER, 16'sd0);
    offer_cmd(KIND_NOP, 16'sd0);
    offer_cmd(KIND_STORE, 16'sh8000);
    offer_cmd(KIND_RECOVER, 16'sd0);
    offer_cmd(KIND_STORE, 16'sd998);
    offer_cmd(KIND_ERASE, 16'sh7fff);
    wait_drained();
  endtask

  task automatic test_ring_wrap();
    offer_cmd(KIND_ERASE, 16'sd0);
    for (int k = 0; k < SLOTS; k++) offer_cmd(KIND_STORE, below_mark());
    offer_cmd(KIND_STORE, count_value());
    for (int k = 1; k < SLOTS; k++) offer_cmd(KIND_STORE, below_mark());
    offer_cmd(KIND_RECOVER, 16'sd0);
    offer_cmd(KIND_NOP, 16'sd0);
    offer_cmd(KIND_STORE, below_mark());
    offer_cmd(KIND_RECOVER, 16'sd0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    holds_asked++;
    steady = 1'b1;
    for (int k = 0; k < 16; k++) begin
      if (k % 5 == 4) offer_cmd(KIND_RECOVER, 16'sd0);
      else offer_cmd(KIND_STORE, count_value());
    end
    steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_mix(input int n);
    int unsigned pick;
    for (int k = 0; k < n; k++) begin
      if (k % 120 == 60) steady = 1'b1;
      if (k % 120 == 90) steady = 1'b0;
      if (k % 150 == 149) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 80) offer_cmd(KIND_STORE, count_value());
      else if (pick < 92) offer_cmd(KIND_RECOVER, CNT_W'($urandom));
      else if (pick < 94) offer_cmd(KIND_ERASE, CNT_W'($urandom));
      else offer_cmd(KIND_NOP, CNT_W'($urandom));
    end
    steady = 1'b0;
    wait_drained();
  endtask

  initial begin
    wipe_model();
    model_last = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_ring_wrap();
    test_backpressure();
    test_random_mix(408);
    repeat (SLOTS + 8) @(posedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("wear_leveled_count_log regression: pass");
    end else begin
      $display("wear_leveled_count_log regression: fail");
    end
    $finish;
  end

endmodule
